### rtl/core/ordered_array_insert_erase_defines.svh
// Assertion helpers for the ordered array block.
// Both expect signals named clk and rst in the using scope.
`ifndef ORDERED_ARRAY_INSERT_ERASE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_ERASE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define OAIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define OAIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/oaie_pkg.sv
`timescale 1ns / 1ps

package oaie_pkg;

  // Operation codes; six and seven are accepted and do nothing
  typedef enum logic [2:0] {
    ACT_INSERT,
    ACT_ERASE,
    ACT_READ,
    ACT_RESIZE,
    ACT_PUSH,
    ACT_POP
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_BADPOS,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    action_t            action;
    logic [8:0]         position;
    logic [8:0]         new_size;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [8:0]         size_now;
    logic [8:0]         capacity_now;
    status_t            status;
  } rsp_word_t;

endpackage

### rtl/core/oaie_mem.sv
`timescale 1ns / 1ps

module oaie_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

### rtl/core/oaie_ctrl.sv
`timescale 1ns / 1ps
`include "ordered_array_insert_erase_defines.svh"

module oaie_ctrl #(
  parameter int DEPTH        = 256,
  parameter int ELEMENT_BITS = 32,
  localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  oaie_pkg::req_word_t     req,
  output logic                    res_valid,
  input  logic                    res_take,
  output oaie_pkg::rsp_word_t     res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [ELEMENT_BITS-1:0] mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [ELEMENT_BITS-1:0] mem_rdata
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_FLUSH,
    S_FILL,
    S_RD,
    S_RD_DATA
  } state_t;

  // S_DONE kept apart so the enum stays dense
  logic done;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           cap;
  logic [CW-1:0]           cursor;
  logic [CW-1:0]           last;
  logic [ELEMENT_BITS-1:0] elem;
  logic                    pend_valid;
  logic [AW-1:0]           pend_addr;
  oaie_pkg::status_t       status;
  logic signed [31:0]      rd_value;

  logic [CW-1:0]           cur_dn;
  logic [CW-1:0]           cur_up;
  logic [CW:0]             cap_dbl;
  logic [CW-1:0]           cap_grow;
  logic [31:0]             pos32;
  logic [31:0]             cnt32;
  logic [31:0]             nsz32;
  logic [31:0]             ipos32;
  logic [63:0]             val64;
  logic signed [ELEMENT_BITS-1:0] rd_elem;
  logic signed [63:0]      rd64;
  logic                    accept;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && !done;
  assign cur_dn    = cursor - 1'b1;
  assign cur_up    = cursor + 1'b1;
  assign pos32     = 32'(req.position);
  assign cnt32     = 32'(count);
  assign nsz32     = 32'(req.new_size);
  assign ipos32    = (req.action == oaie_pkg::ACT_PUSH) ? cnt32 : pos32;
  assign val64     = 64'(req.value);
  assign rd_elem   = mem_rdata;
  assign rd64      = 64'(rd_elem);
  assign cap_dbl   = {cap, 1'b0};

  // Capacity after an insert into a full list: 0 -> 1, then double, clamp at depth
  always_comb begin
    if (count != cap) begin
      cap_grow = cap;
    end else if (cap == '0) begin
      cap_grow = CW'(1);
    end else if (32'(cap_dbl) > DEPTH) begin
      cap_grow = CW'(DEPTH);
    end else begin
      cap_grow = cap_dbl[CW-1:0];
    end
  end

  // Drive the memory ports: a pending shift write wins over new data
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    if (pend_valid) begin
      mem_we = 1'b1;
    end else if (state == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = last[AW-1:0];
      mem_wdata = elem;
    end else if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = cursor[AW-1:0];
      mem_wdata = elem;
    end
    case (state)
      S_SHIFT_UP: mem_raddr = cur_dn[AW-1:0];
      S_SHIFT_DN: mem_raddr = cursor[AW-1:0];
      default:    mem_raddr = last[AW-1:0];
    endcase
  end

  assign res_valid        = done;
  assign res.read_value   = rd_value;
  assign res.size_now     = 9'(count);
  assign res.capacity_now = 9'(cap);
  assign res.status       = status;

  // Sequencer: decode on accept, walk the memory, then hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      count      <= '0;
      cap        <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (done) begin
            if (res_take) begin
              done <= 1'b0;
            end
          end else if (accept) begin
            rd_value <= '0;
            status   <= oaie_pkg::ST_OK;
            elem     <= val64[ELEMENT_BITS-1:0];
            done     <= 1'b1;
            case (req.action)
              oaie_pkg::ACT_INSERT, oaie_pkg::ACT_PUSH: begin
                if (cnt32 >= DEPTH) begin
                  status <= oaie_pkg::ST_FULL;
                end else if (ipos32 > cnt32) begin
                  status <= oaie_pkg::ST_BADPOS;
                end else begin
                  cap    <= cap_grow;
                  count  <= count + 1'b1;
                  cursor <= count;
                  last   <= CW'(ipos32);
                  done   <= 1'b0;
                  state  <= (ipos32 < cnt32) ? S_SHIFT_UP : S_PUT;
                end
              end
              oaie_pkg::ACT_ERASE: begin
                if (count == '0) begin
                  status <= oaie_pkg::ST_EMPTY;
                end else if (pos32 >= cnt32) begin
                  status <= oaie_pkg::ST_BADPOS;
                end else begin
                  count  <= count - 1'b1;
                  cursor <= CW'(pos32 + 32'd1);
                  last   <= count;
                  if (pos32 + 32'd1 < cnt32) begin
                    done  <= 1'b0;
                    state <= S_SHIFT_DN;
                  end
                end
              end
              oaie_pkg::ACT_READ: begin
                if (pos32 < cnt32) begin
                  last  <= CW'(pos32);
                  done  <= 1'b0;
                  state <= S_RD;
                end else begin
                  status <= oaie_pkg::ST_BADPOS;
                end
              end
              oaie_pkg::ACT_RESIZE: begin
                if (nsz32 > DEPTH) begin
                  status <= oaie_pkg::ST_FULL;
                end else if (nsz32 <= cnt32) begin
                  count <= CW'(nsz32);
                end else begin
                  if (nsz32 > 32'(cap)) begin
                    cap <= CW'(nsz32);
                  end
                  count  <= CW'(nsz32);
                  cursor <= count;
                  last   <= CW'(nsz32);
                  done   <= 1'b0;
                  state  <= S_FILL;
                end
              end
              oaie_pkg::ACT_POP: begin
                if (count == '0) begin
                  status <= oaie_pkg::ST_EMPTY;
                end else begin
                  count <= count - 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          // Read entry below, write it one place up next cycle
          pend_valid <= 1'b1;
          pend_addr  <= cursor[AW-1:0];
          cursor     <= cur_dn;
          if (cur_dn == last) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!pend_valid) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT_DN: begin
          // Read entry above, write it one place down next cycle
          pend_valid <= 1'b1;
          pend_addr  <= cur_dn[AW-1:0];
          cursor     <= cur_up;
          if (cur_up == last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_FILL: begin
          cursor <= cur_up;
          if (cur_up == last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          rd_value <= rd64[31:0];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OAIE_ASSERT_NOW(a_count_bound, 1'b1, 32'(count) <= DEPTH, "element count above depth")
  `OAIE_ASSERT_NOW(a_cap_covers, 1'b1, cap >= count, "capacity below element count")
  `OAIE_ASSERT_NOW(a_idle_quiet, state == S_IDLE, !mem_we, "memory written while idle")
  `OAIE_ASSERT_NEXT(a_accept_busy, accept, !req_ready, "new word taken while busy")

endmodule

### rtl/core/ordered_array_insert_erase.sv
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed elements kept in one simple dual-port RAM.
// Request channel req_valid/req_ready/req carries one word per operation:
// insert, erase, read, resize, push back or pop back. Response channel
// rsp_valid/rsp_ready/rsp returns exactly one word per request with the read
// value, element count, nominal capacity and a status code.
// Items are processed one at a time. Pop, shrinking resize, erase of the last
// entry, unused codes and failed operations finish at acceptance; push or
// insert at the end writes the new entry and a read waits for the registered
// RAM output. Insert before the end first moves each later entry up one place,
// erase moves each later entry down one place and resize growth fills each new
// entry with the request value, paced by the single RAM write port, which
// moves one entry per cycle. The request side is ready again in the same cycle
// as rsp_valid rises at the earliest. The response sits in an output register,
// so a waiting response does not hold the request side; when the register is
// still full at the end of the next item, that item holds its result and the
// request side stalls until rsp_ready frees the register.
// Synchronous reset empties the list and zeroes the capacity; RAM contents are
// not cleared, and no entry below the count is ever unwritten.
module ordered_array_insert_erase #(
  parameter int DEPTH        = 256,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  oaie_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output oaie_pkg::rsp_word_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    res_valid;
  logic                    res_take;
  oaie_pkg::rsp_word_t     res;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [ELEMENT_BITS-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [ELEMENT_BITS-1:0] mem_rdata;

  oaie_ctrl #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  oaie_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEMENT_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Take a finished word when the output register is empty or draining
  assign res_take = !rsp_valid || rsp_ready;

  // Hold the response word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule
